// ===== rtl/ffa_pkg.sv =====
// Shared types, codes and command set of the first-fit heap allocator.
package ffa_pkg;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NO_SPACE    = 2'd1;
	localparam logic [1:0] ST_BAD_ADDRESS = 2'd2;

	localparam logic [23:0] HEAP_INITIAL_RESET = 24'h100000;
	localparam logic [23:0] HEAP_LIMIT_RESET   = 24'hFFFFFF;

	localparam logic REG_HEAP_INITIAL = 1'b0;
	localparam logic REG_HEAP_LIMIT   = 1'b1;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic [23:0] start;
		logic [23:0] len;
		logic        free;
	} entry_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_FORM,
		OP_SCAN_RD,
		OP_SCAN_CHK,
		OP_GROW,
		OP_RES_NOSPACE,
		OP_RES_BAD,
		OP_RES_OK,
		OP_TAKE,
		OP_SPLIT_PREP,
		OP_INS_RD,
		OP_INS_WR,
		OP_INS_FIN,
		OP_FREE_HIT,
		OP_REM_RD,
		OP_REM_WR,
		OP_REM_FIN,
		OP_NXT_RD,
		OP_MERGE_NEXT,
		OP_WCUR,
		OP_EMIT
	} op_t;

	typedef struct packed {
		logic req_free;
		logic rel_zero;
		logic formed;
		logic scan_hit;
		logic scan_last;
		logic grow_ok;
		logic split_ok;
		logic prev_merge;
		logic has_next;
		logic nxt_free;
		logic ins_more;
		logic rem_more;
	} st_t;

endpackage

// ===== rtl/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: configuration registers and unit wiring.
//
//  channel   signals                                      direction
//  request   in_valid/in_stall, req_type, alloc_bytes,    in
//            release_offset
//  result    out_valid/out_stall, status, payload_offset  out
//  config    psel, penable, pwrite, paddr, pwdata, prdata in/out
//
// One request is worked at a time; the table sits in a memory with one read and one
// write port, so a scan takes a read and a check state per table entry and each
// shifted entry takes a read and a write state.
// Reset clears the sequencer, block count and heap state; the table needs no clearing.
// A finished result waits in the output register while the next request is taken.
module first_fit_heap_allocator #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [23:0] alloc_bytes,
	input  logic [23:0] release_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [23:0] payload_offset,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ffa_pkg::*;

	logic [23:0] heap_initial_q, heap_limit_q;
	st_t         st;
	op_t         op;

	assign pready = 1'b1;
	assign prdata = {8'd0, (paddr[2] == REG_HEAP_LIMIT) ? heap_limit_q : heap_initial_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_initial_q <= HEAP_INITIAL_RESET;
			heap_limit_q   <= HEAP_LIMIT_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_HEAP_INITIAL)
				heap_initial_q <= pwdata[23:0];
			else
				heap_limit_q <= pwdata[23:0];
		end
	end

	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.op        (op)
	);

	ffa_dp #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.st             (st),
		.heap_initial   (heap_initial_q),
		.heap_limit     (heap_limit_q),
		.req_type       (req_type),
		.alloc_bytes    (alloc_bytes),
		.release_offset (release_offset),
		.status         (status),
		.payload_offset (payload_offset)
	);

`ifndef ASSERT_OFF
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request beat accepted while sequencer idle twice");
	a_formed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(st.formed) |-> st.formed)
		else $error("heap formed flag dropped");
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised without a request in progress");
`endif

endmodule

// ===== rtl/ffa_ctrl.sv =====
// Sequencer that steps the allocator datapath through form, scan, grow, split, merge and shifts.
module ffa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  ffa_pkg::st_t  st,
	output ffa_pkg::op_t  op
);
	import ffa_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_FORM, S_SCAN_RD, S_SCAN_CHK, S_FAIL_BAD, S_GROW,
		S_A_SPLIT, S_INS_RD, S_INS_WR, S_FREE_HIT, S_REM_RD, S_REM_WR,
		S_NXT, S_NXT_CHK, S_WCUR, S_EMIT
	} state_t;

	state_t state_q, state_d;
	logic   after_wcur_q, after_wcur_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		after_wcur_d = after_wcur_q;
		op           = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (!st.req_free) begin
					state_d = st.formed ? S_SCAN_RD : S_FORM;
				end else if (st.rel_zero) begin
					op      = OP_RES_OK;
					state_d = S_EMIT;
				end else if (!st.formed) begin
					op      = OP_RES_BAD;
					state_d = S_EMIT;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_FORM: begin
				op      = OP_FORM;
				state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				op      = OP_SCAN_RD;
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				op = OP_SCAN_CHK;
				if (st.scan_hit)
					state_d = st.req_free ? S_FREE_HIT : S_A_SPLIT;
				else if (st.scan_last)
					state_d = st.req_free ? S_FAIL_BAD : S_GROW;
				else
					state_d = S_SCAN_RD;
			end
			S_FAIL_BAD: begin
				op      = OP_RES_BAD;
				state_d = S_EMIT;
			end
			S_GROW: begin
				if (st.grow_ok) begin
					op      = OP_GROW;
					state_d = S_A_SPLIT;
				end else begin
					op      = OP_RES_NOSPACE;
					state_d = S_EMIT;
				end
			end
			S_A_SPLIT: begin
				if (st.split_ok) begin
					op      = OP_SPLIT_PREP;
					state_d = S_INS_RD;
				end else begin
					op      = OP_TAKE;
					state_d = S_WCUR;
				end
			end
			S_INS_RD: begin
				if (st.ins_more) begin
					op      = OP_INS_RD;
					state_d = S_INS_WR;
				end else begin
					op      = OP_INS_FIN;
					state_d = S_WCUR;
				end
			end
			S_INS_WR: begin
				op      = OP_INS_WR;
				state_d = S_INS_RD;
			end
			S_FREE_HIT: begin
				op           = OP_FREE_HIT;
				after_wcur_d = 1'b0;
				state_d      = st.prev_merge ? S_REM_RD : S_NXT;
			end
			S_REM_RD: begin
				if (st.rem_more) begin
					op      = OP_REM_RD;
					state_d = S_REM_WR;
				end else begin
					op      = OP_REM_FIN;
					state_d = after_wcur_q ? S_WCUR : S_NXT;
				end
			end
			S_REM_WR: begin
				op      = OP_REM_WR;
				state_d = S_REM_RD;
			end
			S_NXT: begin
				if (st.has_next) begin
					op      = OP_NXT_RD;
					state_d = S_NXT_CHK;
				end else begin
					state_d = S_WCUR;
				end
			end
			S_NXT_CHK: begin
				if (st.nxt_free) begin
					op           = OP_MERGE_NEXT;
					after_wcur_d = 1'b1;
					state_d      = S_REM_RD;
				end else begin
					state_d = S_WCUR;
				end
			end
			S_WCUR: begin
				op      = OP_WCUR;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					op      = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			after_wcur_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			after_wcur_q <= after_wcur_d;
			if (op == OP_EMIT)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/ffa_dp.sv =====
// Datapath of the allocator: block table memory, working registers and arithmetic.
module ffa_dp #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ffa_pkg::op_t  op,
	output ffa_pkg::st_t  st,
	input  logic [23:0]   heap_initial,
	input  logic [23:0]   heap_limit,
	input  logic          req_type,
	input  logic [23:0]   alloc_bytes,
	input  logic [23:0]   release_offset,
	output logic [1:0]    status,
	output logic [23:0]   payload_offset
);
	import ffa_pkg::*;

	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [23:0] HDR = 24'(HEADER_BYTES);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
	localparam logic [CW-1:0] ONE = CW'(1);

	entry_t        mem [MAX_BLOCKS];
	entry_t        rd_q, cur_q, prv_q, nxt_q;
	logic [CW-1:0] cnt_q, idx_q, hit_q;
	logic [23:0]   total_q, bytes_q, rel_q;
	logic          formed_q, free_q;
	logic [1:0]    res_st_q;
	logic [23:0]   res_off_q;

	logic [AW-1:0] rda, wra;
	logic          we;
	entry_t        wd;
	logic [23:0]   size;
	logic [24:0]   nt1;
	logic [25:0]   nt2;
	logic          hit_alloc, hit_free;

	assign size      = (heap_initial < HDR) ? HDR : heap_initial;
	assign nt1       = {1'b0, total_q} + {1'b0, bytes_q};
	assign nt2       = {1'b0, nt1} + {2'b0, HDR};
	assign hit_alloc = rd_q.free && (rd_q.len >= bytes_q);
	assign hit_free  = (({1'b0, rd_q.start} + {1'b0, HDR}) == {1'b0, rel_q});

	always_comb begin
		st.req_free   = free_q;
		st.rel_zero   = (rel_q == 24'd0);
		st.formed     = formed_q;
		st.scan_hit   = free_q ? hit_free : hit_alloc;
		st.scan_last  = ((idx_q + ONE) == cnt_q);
		st.grow_ok    = cur_q.free ? (nt1 <= {1'b0, heap_limit})
		                           : ((nt2 <= {2'b0, heap_limit}) && (cnt_q < MAXC));
		st.split_ok   = ((cur_q.len - bytes_q) > HDR) && (cnt_q < MAXC);
		st.prev_merge = (hit_q != '0) && prv_q.free;
		st.has_next   = ((hit_q + ONE) < cnt_q);
		st.nxt_free   = rd_q.free;
		st.ins_more   = (idx_q > (hit_q + ONE));
		st.rem_more   = ((idx_q + ONE) < cnt_q);
	end

	always_comb begin
		rda = idx_q[AW-1:0];
		case (op)
			OP_INS_RD: rda = AW'(idx_q - ONE);
			OP_REM_RD: rda = AW'(idx_q + ONE);
			OP_NXT_RD: rda = AW'(hit_q + ONE);
			default:   rda = idx_q[AW-1:0];
		endcase
	end

	always_comb begin
		we  = 1'b0;
		wra = idx_q[AW-1:0];
		wd  = rd_q;
		case (op)
			OP_FORM: begin
				we  = 1'b1;
				wra = '0;
				wd  = '{start: 24'd0, len: size - HDR, free: 1'b1};
			end
			OP_INS_WR, OP_REM_WR: begin
				we = 1'b1;
			end
			OP_INS_FIN: begin
				we  = 1'b1;
				wra = AW'(hit_q + ONE);
				wd  = nxt_q;
			end
			OP_WCUR: begin
				we  = 1'b1;
				wra = hit_q[AW-1:0];
				wd  = cur_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wra] <= wd;
		rd_q <= mem[rda];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			total_q  <= '0;
			formed_q <= 1'b0;
		end else begin
			case (op)
				OP_FORM: begin
					cnt_q    <= ONE;
					total_q  <= size;
					formed_q <= 1'b1;
				end
				OP_GROW: begin
					if (cur_q.free) begin
						total_q <= nt1[23:0];
					end else begin
						total_q <= nt2[23:0];
						cnt_q   <= cnt_q + ONE;
					end
				end
				OP_INS_FIN: cnt_q <= cnt_q + ONE;
				OP_REM_FIN: cnt_q <= cnt_q - ONE;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				free_q  <= (req_type == REQ_FREE);
				bytes_q <= alloc_bytes;
				rel_q   <= release_offset;
				idx_q   <= '0;
			end
			OP_SCAN_CHK: begin
				prv_q <= cur_q;
				cur_q <= rd_q;
				if ((free_q ? hit_free : hit_alloc))
					hit_q <= idx_q;
				else
					idx_q <= idx_q + ONE;
			end
			OP_GROW: begin
				if (cur_q.free) begin
					cur_q.len <= cur_q.len + bytes_q;
					hit_q     <= cnt_q - ONE;
				end else begin
					cur_q <= '{start: total_q, len: bytes_q, free: 1'b1};
					hit_q <= cnt_q;
				end
			end
			OP_SPLIT_PREP: begin
				nxt_q      <= '{start: cur_q.start + HDR + bytes_q,
				                len: cur_q.len - HDR - bytes_q, free: 1'b1};
				cur_q.len  <= bytes_q;
				cur_q.free <= 1'b0;
				idx_q      <= cnt_q;
			end
			OP_TAKE:   cur_q.free <= 1'b0;
			OP_INS_WR: idx_q <= idx_q - ONE;
			OP_REM_WR: idx_q <= idx_q + ONE;
			OP_FREE_HIT: begin
				if (st.prev_merge) begin
					cur_q <= '{start: prv_q.start, len: prv_q.len + HDR + cur_q.len,
					           free: 1'b1};
					idx_q <= hit_q;
					hit_q <= hit_q - ONE;
				end else begin
					cur_q.free <= 1'b1;
				end
			end
			OP_MERGE_NEXT: begin
				cur_q.len <= cur_q.len + HDR + rd_q.len;
				idx_q     <= hit_q + ONE;
			end
			OP_RES_OK: begin
				res_st_q  <= ST_OK;
				res_off_q <= 24'd0;
			end
			OP_RES_BAD: begin
				res_st_q  <= ST_BAD_ADDRESS;
				res_off_q <= 24'd0;
			end
			OP_RES_NOSPACE: begin
				res_st_q  <= ST_NO_SPACE;
				res_off_q <= 24'd0;
			end
			OP_WCUR: begin
				res_st_q  <= ST_OK;
				res_off_q <= free_q ? 24'd0 : cur_q.start + HDR;
			end
			OP_EMIT: begin
				status         <= res_st_q;
				payload_offset <= res_off_q;
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/sv/tb_first_fit_heap_allocator.sv =====
// Self-checking testbench of the first-fit heap allocator with a table-based predictor.
module tb_first_fit_heap_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import ffa_pkg::*;

	localparam int NBLK = 64;
	localparam int HDR = 32;
	localparam int WATCH_LIMIT = 40000;

	typedef struct {
		logic [1:0]  status;
		logic [23:0] offset;
	} alloc_result_t;

	class heap_scoreboard;
		logic [23:0] b_start[NBLK];
		logic [23:0] b_len[NBLK];
		bit          b_free[NBLK];
		int          count;
		logic [23:0] total;
		bit          formed;
		logic [23:0] init_sz;
		logic [23:0] limit_sz;
		alloc_result_t pending[$];
		int mismatches;
		int results_seen;

		function new();
			count = 0;
			total = 0;
			formed = 0;
			init_sz = HEAP_INITIAL_RESET;
			limit_sz = HEAP_LIMIT_RESET;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void drop_at(int idx);
			for (int k = idx; k + 1 < count; k++) begin
				b_start[k] = b_start[k+1];
				b_len[k] = b_len[k+1];
				b_free[k] = b_free[k+1];
			end
			count--;
		endfunction

		function void put_at(int idx, logic [23:0] s, logic [23:0] l, bit f);
			for (int k = count; k > idx; k--) begin
				b_start[k] = b_start[k-1];
				b_len[k] = b_len[k-1];
				b_free[k] = b_free[k-1];
			end
			b_start[idx] = s;
			b_len[idx] = l;
			b_free[idx] = f;
			count++;
		endfunction

		function alloc_result_t do_alloc(logic [23:0] req);
			alloc_result_t r;
			int hit;
			int last;
			logic [25:0] nt;
			logic [23:0] sz;
			r.status = ST_OK;
			r.offset = 0;
			if (!formed) begin
				sz = (init_sz < HDR) ? 24'(HDR) : init_sz;
				count = 0;
				put_at(0, 0, 24'(sz - HDR), 1);
				total = sz;
				formed = 1;
			end
			hit = count;
			for (int i = 0; i < count; i++)
				if (b_free[i] && b_len[i] >= req) begin
					hit = i;
					break;
				end
			if (hit == count) begin
				last = count - 1;
				if (b_free[last]) begin
					nt = {2'b0, total} + {2'b0, req};
					if (nt > limit_sz) begin
						r.status = ST_NO_SPACE;
						return r;
					end
					b_len[last] += req;
					total = nt[23:0];
					hit = last;
				end else begin
					nt = {2'b0, total} + 26'(HDR) + {2'b0, req};
					if (nt > limit_sz || count >= NBLK) begin
						r.status = ST_NO_SPACE;
						return r;
					end
					put_at(count, total, req, 1);
					total = nt[23:0];
					hit = count - 1;
				end
			end
			if (b_len[hit] - req > HDR && count < NBLK) begin
				put_at(hit + 1, 24'(b_start[hit] + HDR + req), 24'(b_len[hit] - HDR - req), 1);
				b_len[hit] = req;
			end
			b_free[hit] = 0;
			r.offset = 24'(b_start[hit] + HDR);
			return r;
		endfunction

		function alloc_result_t do_release(logic [23:0] off);
			alloc_result_t r;
			int hit;
			r.status = ST_OK;
			r.offset = 0;
			if (off == 0) return r;
			r.status = ST_BAD_ADDRESS;
			if (!formed) return r;
			hit = count;
			for (int i = 0; i < count; i++)
				if ({1'b0, b_start[i]} + HDR == {1'b0, off}) begin
					hit = i;
					break;
				end
			if (hit == count) return r;
			r.status = ST_OK;
			b_free[hit] = 1;
			if (hit > 0 && b_free[hit-1]) begin
				b_len[hit-1] = 24'(b_len[hit-1] + HDR + b_len[hit]);
				drop_at(hit);
				hit--;
			end
			if (hit + 1 < count && b_free[hit+1]) begin
				b_len[hit] = 24'(b_len[hit] + HDR + b_len[hit+1]);
				drop_at(hit + 1);
			end
			return r;
		endfunction

		function void note_request(logic rt, logic [23:0] nb, logic [23:0] off);
			pending.push_back(rt == REQ_ALLOC ? do_alloc(nb) : do_release(off));
		endfunction

		function void check_result(logic [1:0] st, logic [23:0] po);
			alloc_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat st=%0d off=%h", st, po);
				return;
			end
			e = pending.pop_front();
			if (st !== e.status || po !== e.offset) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp st=%0d off=%h got st=%0d off=%h",
						e.status, e.offset, st, po);
			end
		endfunction

		function logic [23:0] some_offset();
			if (count == 0) return 24'(HDR);
			return 24'(b_start[$urandom_range(count - 1)] + HDR);
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, req_type = 0;
	logic [23:0] alloc_bytes = 0, release_offset = 0;
	logic out_valid, out_stall = 0;
	logic [1:0] status;
	logic [23:0] payload_offset;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready;

	heap_scoreboard sb = new();
	int send_idle = 8, recv_idle = 48;
	bit hold_recv = 0;
	int watch = 0;
	int n_alloc = 0, n_free = 0;

	first_fit_heap_allocator u_top (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(status, payload_offset);
		if (hold_recv) out_stall <= 1;
		else out_stall <= ($urandom_range(99) < recv_idle);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) watch = 0;
		else watch++;
		if (watch >= WATCH_LIMIT) begin
			$display("watchdog expired");
			$display("tb_first_fit_heap_allocator: FAIL");
			$finish;
		end
	end

	task automatic reg_write(logic idx, logic [23:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= {8'h0, v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_HEAP_INITIAL) sb.init_sz = v; else sb.limit_sz = v;
	endtask

	task automatic send_req(logic rt, logic [23:0] nb, logic [23:0] off);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		req_type <= rt; alloc_bytes <= nb; release_offset <= off; in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(rt, nb, off);
		if (rt == REQ_ALLOC) n_alloc++; else n_free++;
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 50)
				send_req(REQ_ALLOC, (r < 45) ? 24'($urandom_range(200)) : 24'($urandom),
					24'($urandom));
			else if (r < 88)
				send_req(REQ_FREE, 24'($urandom), sb.some_offset());
			else if (r < 94)
				send_req(REQ_FREE, 24'($urandom), 0);
			else
				send_req(REQ_FREE, 24'($urandom), 24'($urandom));
		end
	endtask

	task automatic new_heap(logic [23:0] init_v, logic [23:0] lim_v);
		drain();
		reg_write(REG_HEAP_INITIAL, init_v);
		reg_write(REG_HEAP_LIMIT, lim_v);
		send_req(REQ_FREE, 0, sb.some_offset());
		while (sb.count > 0) begin
			send_req(REQ_FREE, 0, 24'(sb.b_start[$urandom_range(sb.count - 1)] + HDR));
			if (sb.count == 1 && sb.b_free[0]) break;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_req(REQ_FREE, 0, 24'h000020);
		send_req(REQ_FREE, 0, 0);
		send_req(REQ_ALLOC, 24'h000000, 24'hFFFFFF);
		send_req(REQ_ALLOC, 24'h000010, 0);
		send_req(REQ_ALLOC, 24'hFFFFFF, 0);
		send_req(REQ_FREE, 0, 24'h000020);
		send_req(REQ_FREE, 0, 24'h000020);
		send_req(REQ_FREE, 0, 24'h000021);
		send_req(REQ_FREE, 0, 24'hFFFFFF);
		drain();
		reg_write(REG_HEAP_INITIAL, 24'd64);
		reg_write(REG_HEAP_LIMIT, 24'd64);
		drain();
		random_phase(1);
		fork
			begin
				hold_recv = 1;
				repeat (400) @(posedge clk);
				hold_recv = 0;
			end
			for (int i = 0; i < 12; i++) send_req(REQ_ALLOC, 24'(i * 3), 0);
		join
		drain();
		reg_write(REG_HEAP_LIMIT, 24'hFFFFFF);
		for (int i = 0; i < 70; i++) send_req(REQ_ALLOC, 24'd8, 0);
		send_req(REQ_ALLOC, 24'd5000, 0);
		random_phase(200);
		new_heap(24'd10, 24'd2000);
		random_phase(200);
		send_idle = 48; recv_idle = 8;
		new_heap(24'hFFFFFF, 24'd64);
		random_phase(130);
		send_idle = 0; recv_idle = 0;
		new_heap(24'd300, 24'd4000);
		random_phase(130);
		drain();
		$display("covered %0d allocates and %0d frees, %0d results checked, %0d mismatches",
			n_alloc, n_free, sb.results_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb_first_fit_heap_allocator: PASS");
		else
			$display("tb_first_fit_heap_allocator: FAIL");
		$finish;
	end
endmodule

// ===== first_fit_heap_allocator.f =====
rtl/ffa_pkg.sv
rtl/ffa_ctrl.sv
rtl/ffa_dp.sv
rtl/first_fit_heap_allocator.sv
tb/sv/tb_first_fit_heap_allocator.sv
